// File: src/swm_pkg.sv
package swm_pkg;

  // default build values
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 30;

  // configuration word width
  localparam int CFG_W = 7;

  // window size after reset
  localparam int WSIZE_RESET = 1;

  // per-word control shared by every cell
  typedef struct packed {
    logic acc;      // word accepted this cycle
    logic clr;      // empty the window
    logic full;     // window full before the word enters, restart applied
    logic restart;  // word carries restart
  } cell_ctl_t;

  // what a cell shows the cell below it
  typedef struct packed {
    logic v;   // holds a sample
    logic le;  // sample is <= incoming sample
  } cell_a_t;

  // what a cell shows the cell above it, after the eviction
  typedef struct packed {
    logic v;   // entry after eviction is occupied
    logic le;  // entry after eviction is occupied and <= incoming sample
  } cell_b_t;

endpackage

// File: src/swm_if.sv
interface swm_in_if #(
  parameter int SW = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [SW-1:0] sample;
  logic          restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface swm_out_if #(
  parameter int SW = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [SW-1:0] median;

  modport source (output valid, median, input ready);
  modport sink   (input valid, median, output ready);
endinterface

interface swm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [swm_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: src/swm_cell.sv
module swm_cell #(
  parameter int SW    = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int AGE_W = 6,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::cell_ctl_t ctl,
  input  logic [SW-1:0]      sample,
  input  logic [SW-1:0]      old_val,
  input  logic [AGE_W-1:0]   wm1,
  input  logic [AGE_W-1:0]   mid,
  // neighbour above
  input  logic [SW-1:0]      up_val,
  input  logic [AGE_W-1:0]   up_age,
  input  swm_pkg::cell_a_t   up_a,
  // neighbour below
  input  logic [SW-1:0]      dn_val,
  input  logic [AGE_W-1:0]   dn_age,
  input  swm_pkg::cell_b_t   dn_b,
  // own view
  output logic [SW-1:0]      a_val,
  output logic [AGE_W-1:0]   a_age,
  output swm_pkg::cell_a_t   a_out,
  output logic [SW-1:0]      b_val,
  output logic [AGE_W-1:0]   b_age,
  output swm_pkg::cell_b_t   b_out,
  output logic [SW-1:0]      rm_val,
  output logic [SW-1:0]      tap_val
);

  logic             valid_r, valid_nxt;
  logic [SW-1:0]    val_r, val_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             v_eff;
  logic             shift;

  assign v_eff = valid_r & ~ctl.restart;
  // evicted entry sits at or below this cell
  assign shift = v_eff & ctl.full & (val_r >= old_val);

  assign a_val    = val_r;
  assign a_age    = age_r;
  assign a_out.v  = v_eff;
  assign a_out.le = (val_r <= sample);

  // entry after the oldest sample is taken out
  assign b_val    = shift ? up_val : val_r;
  assign b_age    = shift ? up_age : age_r;
  assign b_out.v  = ctl.full ? up_a.v : v_eff;
  assign b_out.le = b_out.v & (shift ? up_a.le : a_out.le);

  assign rm_val  = (v_eff && ctl.full && age_r == wm1) ? val_r : '0;
  assign tap_val = (valid_r && AGE_W'(IDX) == mid) ? val_r : '0;

  // insertion: keep, take the new sample, or take the entry below
  always_comb begin
    if (b_out.le) begin
      valid_nxt = 1'b1;
      val_nxt   = b_val;
      age_nxt   = b_age + AGE_W'(1);
    end else if (dn_b.le) begin
      valid_nxt = 1'b1;
      val_nxt   = sample;
      age_nxt   = '0;
    end else begin
      valid_nxt = dn_b.v;
      val_nxt   = dn_val;
      age_nxt   = dn_age + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.acc) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

// File: src/sliding_window_median.sv
// sliding window median filter
// in_ch carries one sample word per handshake plus a restart flag that empties
// the window before that sample enters. out_ch carries the lower median of the
// window (sorted position (w-1)/2) for every word accepted while the window is
// full after entry; no word comes out while the window is still filling.
// cfg_ch writes the window size (zero counts as one, sizes above MAX_WINDOW
// saturate) and empties the window; it is always ready and is meant to be
// written only while the filter is idle.
// the samples sit in a row of sorted cells; each accepted word evicts the
// oldest sample and inserts the new one in a single update across the whole row.
// the median reaches out_ch through the cell row update, then the output
// register.
// throughput: one word per cycle while out_ch is taken; set by the single
// row update and the one-word output register.
// reset empties the window, sets the size to one and drops any pending word;
// the cells need no clearing pass.
// when out_ch stalls the pending median waits in the output register and at
// most one more word that completes a median is taken before in_ch.ready falls.
module sliding_window_median #(
  parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WS_W  = $clog2(MAX_WINDOW + 1);

  // window size and fill level
  logic [WS_W-1:0] wsize_r, wsize_nxt;
  logic [WS_W-1:0] fill_r, fill_nxt;
  // output side
  logic            emit_r, emit_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   out_median_r, out_median_nxt;

  logic            in_acc;
  logic            cfg_acc;
  logic            can_load;
  logic            full;
  logic            full_after;
  logic [WS_W-1:0] fill_eff;
  logic [31:0]     cfg_ext;
  logic [IDX_W-1:0] wm1;
  logic [IDX_W-1:0] mid;
  logic [SW-1:0]   old_val;
  logic [SW-1:0]   median_sel;

  swm_pkg::cell_ctl_t ctl;

  // per-cell taps
  logic [SW-1:0]     a_val   [MAX_WINDOW];
  logic [IDX_W-1:0]  a_age   [MAX_WINDOW];
  swm_pkg::cell_a_t  a_fl    [MAX_WINDOW];
  logic [SW-1:0]     b_val   [MAX_WINDOW];
  logic [IDX_W-1:0]  b_age   [MAX_WINDOW];
  swm_pkg::cell_b_t  b_fl    [MAX_WINDOW];
  logic [SW-1:0]     rm_val  [MAX_WINDOW];
  logic [SW-1:0]     tap_val [MAX_WINDOW];

  // handshakes
  assign can_load     = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = ~emit_r | can_load;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_acc      = cfg_ch.valid;

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = out_median_r;

  // window state seen by the incoming word
  assign fill_eff   = in_ch.restart ? '0 : fill_r;
  assign full       = ~in_ch.restart & (fill_r == wsize_r);
  assign full_after = full | ((fill_eff + WS_W'(1)) == wsize_r);

  assign wm1 = IDX_W'(wsize_r - WS_W'(1));
  assign mid = IDX_W'((wsize_r - WS_W'(1)) >> 1);

  assign ctl.acc     = in_acc & ~cfg_acc;
  assign ctl.clr     = cfg_acc;
  assign ctl.full    = full;
  assign ctl.restart = in_ch.restart;

  // oldest sample and median tap, each at most one cell non-zero
  always_comb begin
    old_val    = '0;
    median_sel = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      old_val    = old_val | rm_val[k];
      median_sel = median_sel | tap_val[k];
    end
  end

  // row of sorted cells, lowest value at cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SW-1:0]    up_val;
    logic [IDX_W-1:0] up_age;
    swm_pkg::cell_a_t up_a;
    logic [SW-1:0]    dn_val;
    logic [IDX_W-1:0] dn_age;
    swm_pkg::cell_b_t dn_b;

    if (i < MAX_WINDOW - 1) begin : g_up
      assign up_val = a_val[i+1];
      assign up_age = a_age[i+1];
      assign up_a   = a_fl[i+1];
    end else begin : g_top
      assign up_val = '0;
      assign up_age = '0;
      assign up_a   = '{v: 1'b0, le: 1'b0};
    end

    if (i > 0) begin : g_dn
      assign dn_val = b_val[i-1];
      assign dn_age = b_age[i-1];
      assign dn_b   = b_fl[i-1];
    end else begin : g_bot
      // below cell 0 the new sample always fits
      assign dn_val = '0;
      assign dn_age = '0;
      assign dn_b   = '{v: 1'b0, le: 1'b1};
    end

    swm_cell #(
      .SW    (SW),
      .AGE_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sample  (in_ch.sample),
      .old_val (old_val),
      .wm1     (wm1),
      .mid     (mid),
      .up_val  (up_val),
      .up_age  (up_age),
      .up_a    (up_a),
      .dn_val  (dn_val),
      .dn_age  (dn_age),
      .dn_b    (dn_b),
      .a_val   (a_val[i]),
      .a_age   (a_age[i]),
      .a_out   (a_fl[i]),
      .b_val   (b_val[i]),
      .b_age   (b_age[i]),
      .b_out   (b_fl[i]),
      .rm_val  (rm_val[i]),
      .tap_val (tap_val[i])
    );
  end

  // size write: zero counts as one, large values saturate
  assign cfg_ext = 32'(cfg_ch.data);

  always_comb begin
    wsize_nxt = wsize_r;
    fill_nxt  = fill_r;
    if (cfg_acc) begin
      if (cfg_ext == 32'd0) begin
        wsize_nxt = WS_W'(1);
      end else if (cfg_ext > 32'(MAX_WINDOW)) begin
        wsize_nxt = WS_W'(MAX_WINDOW);
      end else begin
        wsize_nxt = WS_W'(cfg_ext);
      end
      fill_nxt = '0;
    end else if (in_acc) begin
      fill_nxt = full ? fill_r : fill_eff + WS_W'(1);
    end
  end

  // output register: the median is picked once the row update is done and the register can load
  always_comb begin
    emit_nxt       = emit_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    if (emit_r && can_load) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = median_sel;
      emit_nxt       = 1'b0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && !cfg_acc) begin
      emit_nxt = full_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r     <= WS_W'(swm_pkg::WSIZE_RESET);
      fill_r      <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wsize_r     <= wsize_nxt;
      fill_r      <= fill_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_median_r <= out_median_nxt;
  end

endmodule

// File: dv/swm_median_checker.sv
`timescale 1ns / 100ps

module swm_median_checker #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
  parameter int SW         = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [SW-1:0]             in_sample,
  input  logic                      in_restart,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [SW-1:0]             out_median,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending
);

  bit [SW-1:0]             ring_vals   [MAX_WINDOW];
  bit [SW-1:0]             sorted_vals [MAX_WINDOW];
  int unsigned             held;
  int unsigned             oldest;
  bit [swm_pkg::CFG_W-1:0] win_size;
  bit [SW-1:0]             median_q [$];
  int                      bad_count;

  initial begin
    bad_count = 0;
  end

  // zero counts as one, oversize saturates
  function automatic int unsigned live_size();
    int unsigned w;
    w = win_size;
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return w;
  endfunction

  function automatic void insert_sorted(input bit [SW-1:0] v, input int unsigned cnt);
    int unsigned i;
    i = cnt;
    while (i > 0 && sorted_vals[i-1] > v) begin
      sorted_vals[i] = sorted_vals[i-1];
      i--;
    end
    sorted_vals[i] = v;
  endfunction

  // returns 1 when the window is full after the word enters
  function automatic bit take_sample(input bit [SW-1:0] s, input bit rs,
                                     output bit [SW-1:0] med);
    int unsigned w;
    int unsigned i;
    bit [SW-1:0] gone;
    w = live_size();
    if (rs) begin
      held   = 0;
      oldest = 0;
    end
    if (held > w) held = w;
    if (oldest >= w) oldest = 0;
    if (held == w) begin
      // drop one copy of the evicted value
      gone = ring_vals[oldest];
      i = 0;
      while (i < w && sorted_vals[i] != gone) i++;
      for (; i + 1 < w; i++) sorted_vals[i] = sorted_vals[i+1];
      ring_vals[oldest] = s;
      oldest = (oldest + 1) % w;
      insert_sorted(s, w - 1);
    end else begin
      ring_vals[(oldest + held) % w] = s;
      insert_sorted(s, held);
      held++;
    end
    med = sorted_vals[(w - 1) / 2];
    return held == w;
  endfunction

  always @(posedge clk) begin : watch
    bit [SW-1:0] want;
    bit [SW-1:0] med;
    if (!rst_n) begin
      held     = 0;
      oldest   = 0;
      win_size = swm_pkg::CFG_W'(swm_pkg::WSIZE_RESET);
      median_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          $error("median: no word expected, actual %0d", out_median);
          bad_count++;
        end else begin
          want = median_q.pop_front();
          if (out_median !== want) begin
            $error("median: expected %0d, actual %0d", want, out_median);
            bad_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        win_size = cfg_data;
        held     = 0;
        oldest   = 0;
      end
      if (in_valid && in_ready) begin
        if (take_sample(in_sample, in_restart, med)) median_q.push_back(med);
      end
    end
    fails   <= bad_count;
    pending <= median_q.size();
  end

endmodule

// File: dv/tb_sliding_window_median.sv
`timescale 1ns / 100ps

module tb_sliding_window_median;

  localparam int            SW          = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int            CYCLE_LIMIT = 400_000;
  localparam logic [SW-1:0] TOP_SAMPLE  = '1;
  localparam int            PHASES      = 8;
  localparam int            PHASE_WORDS = 250;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycle_count;

  // idling switches, changed between stretches of stimulus
  bit send_idle;
  bit recv_idle;

  swm_in_if  #(.SW(SW)) in_ch ();
  swm_out_if #(.SW(SW)) out_ch ();
  swm_cfg_if            cfg_ch ();

  sliding_window_median #(
    .MAX_WINDOW   (swm_pkg::MAX_WINDOW_DEF),
    .SAMPLE_WIDTH (SW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // watches all three channels, predicts every median and compares
  swm_median_checker #(
    .MAX_WINDOW (swm_pkg::MAX_WINDOW_DEF),
    .SW         (SW)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .in_restart (in_ch.restart),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_median (out_ch.median),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .fails      (fails),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mix of tiny values (many duplicates), values up to 1000, full-range values and values near the top
  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0:       return SW'($urandom_range(0, 7));
      1:       return SW'($urandom);
      2:       return TOP_SAMPLE - SW'($urandom_range(0, 3));
      default: return SW'($urandom_range(0, 1000));
    endcase
  endfunction

  // one sample word; valid stays high across back-to-back words
  task automatic send_word(input logic [SW-1:0] s, input logic rs);
    int gap;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold the sender until every predicted median has come out; a word that only
  // filled the window gives nothing to wait on, so a further wait covers its
  // path through the cell row
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // size writes only ever land on an idle filter
  task automatic write_size(input logic [swm_pkg::CFG_W-1:0] d);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: while recv_idle is set, a fresh random stall for every median word
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    logic [swm_pkg::CFG_W-1:0] sizes [PHASES];
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    rst_n         <= 1'b0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    // full window, oversize, odd, one, just over the row, even, zero, random
    sizes = '{7'd64, 7'd127, 7'd3, 7'd1, 7'd65, 7'd2, 7'd0,
              swm_pkg::CFG_W'($urandom_range(1, 127))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size one out of reset: every word is its own median, restart included
    send_word('0, 1'b0);
    send_word(TOP_SAMPLE, 1'b0);
    send_word(SW'(5), 1'b1);

    // size zero behaves as one
    write_size('0);
    send_word(SW'(7), 1'b0);
    send_word(TOP_SAMPLE, 1'b0);

    // even window gives the lower median; restart on a full window
    write_size(swm_pkg::CFG_W'(2));
    send_word(TOP_SAMPLE, 1'b0);
    send_word('0, 1'b0);
    send_word(TOP_SAMPLE, 1'b0);
    send_word(SW'(1), 1'b1);
    send_word(SW'(2), 1'b0);

    // odd window with duplicate values evicted; restart part way through
    write_size(swm_pkg::CFG_W'(3));
    send_word(SW'(5), 1'b0);
    send_word(SW'(1), 1'b0);
    send_word(SW'(9), 1'b0);
    send_word(SW'(9), 1'b0);
    send_word(SW'(1), 1'b0);
    send_word(SW'(9), 1'b0);
    send_word(SW'(4), 1'b1);
    send_word(SW'(2), 1'b0);
    send_word(SW'(8), 1'b0);

    // random phases, one window size each; restarts rare so big windows fill
    for (int p = 0; p < PHASES; p++) begin
      write_size(sizes[p]);
      send_idle = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      recv_idle = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          send_idle = 1'($urandom_range(0, 1));
          recv_idle = 1'($urandom_range(0, 1));
        end
        // occasionally let the pipe run dry mid-stream
        if ($urandom_range(0, 199) == 0) drain();
        send_word(rand_sample(), ($urandom_range(0, 79) == 0));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/swm_pkg.sv
src/swm_if.sv
src/swm_cell.sv
src/sliding_window_median.sv
dv/swm_median_checker.sv
dv/tb_sliding_window_median.sv
